/* hw/rtl/wtca_pkg.sv */
// Shared types and constants for the weighted three-tap cost aggregation block.
package wtca_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_DISTANCE = 16;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MEM_AW       = 15;   // 2*MAX_DISTANCE*MAX_WIDTH entries
  localparam int POS_W        = 20;
  localparam int CNT_W        = 21;
  localparam int LAG_W        = 15;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = 2;

  localparam logic [1:0] CFG_DIR    = 2'd0;
  localparam logic [1:0] CFG_DIST   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             dir;
    logic [4:0]       tap_dist;
    logic [10:0]      width;
    logic [10:0]      height;
    logic [LAG_W-1:0] lag;
    logic [CNT_W-1:0] fsize;
  } cfg_t;

  typedef struct packed {
    logic             is_pix;
    logic [7:0]       cost;
    logic [7:0]       weight;
    logic [POS_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic idle;
    logic frame_done;
  } back_stat_t;

endpackage

/* hw/rtl/wtca_fifo.sv */
// Short item queue between the front and back parts.
module wtca_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wtca_pkg::item_t push_data,
  input  logic            pop,
  output wtca_pkg::item_t pop_data,
  output logic            full,
  output logic            empty
);

  wtca_pkg::item_t              entry_r [wtca_pkg::Q_DEPTH];
  logic [wtca_pkg::Q_AW-1:0]    wptr_r;
  logic [wtca_pkg::Q_AW-1:0]    rptr_r;
  logic [wtca_pkg::Q_AW:0]      count_r;

  assign full     = (count_r == 3'(wtca_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue underflow");

endmodule

/* hw/rtl/wtca_front.sv */
// Front part: accepts beats, counts frame pixels, classifies pixel and flush items.
module wtca_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wtca_pkg::cfg_t       cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  input  logic                 q_empty,
  output logic                 q_push,
  output wtca_pkg::item_t      q_data,
  input  wtca_pkg::back_stat_t stat
);

  logic [wtca_pkg::CNT_W-1:0] cnt_r;
  logic                       frame_open;
  logic                       accept;

  assign frame_open = (cnt_r < cfg.fsize);
  assign in_tready  = !q_full && (frame_open || (q_empty && stat.idle));
  assign accept     = in_tvalid && in_tready;
  assign q_push     = accept && ((in_tuser == wtca_pkg::REQ_PIXEL) || !frame_open);

  always_comb begin
    q_data.is_pix = (in_tuser == wtca_pkg::REQ_PIXEL) && frame_open;
    q_data.cost   = in_tdata[7:0];
    q_data.weight = in_tdata[15:8];
    q_data.idx    = cnt_r[wtca_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (stat.frame_done) begin
      cnt_r <= '0;
    end else if (q_push && q_data.is_pix) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

/* hw/rtl/wtca_back.sv */
// Back part: delay-line memories, tap reads, weighted sum, serial divide, output register.
module wtca_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wtca_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  wtca_pkg::item_t      q_data,
  output logic                 q_pop,
  output wtca_pkg::back_stat_t stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RQ   = 4'd1;
  localparam logic [3:0] S_RM   = 4'd2;
  localparam logic [3:0] S_RP   = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [7:0] cmem [2**wtca_pkg::MEM_AW];
  logic [7:0] wmem [2**wtca_pkg::MEM_AW];

  logic [3:0]                 state_r;
  wtca_pkg::item_t            it_r;
  logic                       emit_r, hn_r;
  logic [7:0]                 val_r, centre_r, wp_r, wm_r, cm_r;
  logic [7:0]                 rdc_r, rdw_r;
  logic [15:0]                p1_r, p2_r;
  logic [9:0]                 den_r, rem_r;
  logic [7:0]                 nlo_r, quo_r;
  logic [2:0]                 cnt_r;
  logic [wtca_pkg::POS_W-1:0] q_r;
  logic [9:0]                 col_r, row_r;
  logic                       ovalid_r, olast_r;
  logic [7:0]                 odata_r;

  logic [wtca_pkg::POS_W-1:0] qm, qp;
  logic [wtca_pkg::CNT_W-1:0] qlag;
  logic [wtca_pkg::MEM_AW-1:0] rd_addr;
  logic                       border, bypass, load, fe;
  logic [10:0]                sh;
  logic                       ge;
  logic [7:0]                 cp;
  logic [17:0]                num;

  assign qm   = q_r - wtca_pkg::POS_W'(cfg.lag);
  assign qp   = q_r + wtca_pkg::POS_W'(cfg.lag);
  assign qlag = {1'b0, q_r} + wtca_pkg::CNT_W'(cfg.lag);

  always_comb begin
    case (state_r)
      S_RM:    rd_addr = qm[wtca_pkg::MEM_AW-1:0];
      S_RP:    rd_addr = qp[wtca_pkg::MEM_AW-1:0];
      default: rd_addr = q_r[wtca_pkg::MEM_AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WR && it_r.is_pix) begin
      cmem[it_r.idx[wtca_pkg::MEM_AW-1:0]] <= it_r.cost;
      wmem[it_r.idx[wtca_pkg::MEM_AW-1:0]] <= it_r.weight;
    end
    rdc_r <= cmem[rd_addr];
    rdw_r <= wmem[rd_addr];
  end

  always_comb begin
    if (cfg.dir)
      border = ({1'b0, col_r} < 11'(cfg.tap_dist)) ||
               ({1'b0, col_r} + 11'(cfg.tap_dist) >= cfg.width);
    else
      border = ({1'b0, row_r} < 11'(cfg.tap_dist)) ||
               ({1'b0, row_r} + 11'(cfg.tap_dist) >= cfg.height);
    bypass = (cfg.tap_dist == '0) || border || (q_r < wtca_pkg::POS_W'(cfg.lag));
  end

  assign sh  = {rem_r, nlo_r[7]};
  assign ge  = (sh >= {1'b0, den_r});
  assign cp  = (it_r.is_pix && hn_r) ? it_r.cost : rdc_r;
  assign num = 18'(p1_r) + 18'(p2_r) + {2'b0, centre_r, 8'b0} + 18'(den_r[9:1]);

  assign load = (state_r == S_DONE) && (!ovalid_r || out_tready);
  assign fe   = ({1'b0, q_r} + 1'b1 >= cfg.fsize);

  assign q_pop           = (state_r == S_IDLE) && !q_empty;
  assign stat.idle       = (state_r == S_IDLE);
  assign stat.frame_done = load && fe;

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        it_r   <= q_data;
        hn_r   <= (qlag == {1'b0, q_data.idx});
        emit_r <= !q_data.is_pix || (qlag <= {1'b0, q_data.idx});
        val_r  <= q_data.cost;
      end
      S_RM: begin
        centre_r <= rdc_r;
        wp_r     <= rdw_r;
        val_r    <= rdc_r;
      end
      S_RP: begin
        cm_r <= rdc_r;
        wm_r <= rdw_r;
      end
      S_PRD: begin
        p1_r  <= wp_r * cp;
        p2_r  <= wm_r * cm_r;
        den_r <= 10'(wp_r) + 10'(wm_r) + 10'd256;
      end
      S_SUM: begin
        rem_r <= num[17:8];
        nlo_r <= num[7:0];
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= ge ? 10'(sh - {1'b0, den_r}) : sh[9:0];
        nlo_r <= {nlo_r[6:0], 1'b0};
        quo_r <= {quo_r[6:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd7) val_r <= {quo_r[6:0], ge};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.is_pix &&
                ((qlag > {1'b0, q_data.idx}) || (cfg.lag == '0)))
              state_r <= S_WR;
            else
              state_r <= S_RQ;
          end
        end
        S_RQ:   state_r <= S_RM;
        S_RM:   state_r <= bypass ? S_WR : S_RP;
        S_RP:   state_r <= S_PRD;
        S_PRD:  state_r <= S_SUM;
        S_SUM:  state_r <= S_DIV;
        S_DIV:  if (cnt_r == 3'd7) state_r <= S_WR;
        S_WR:   state_r <= emit_r ? S_DONE : S_IDLE;
        S_DONE: if (load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (load) begin
      if (fe) begin
        q_r   <= '0;
        col_r <= '0;
        row_r <= '0;
      end else begin
        q_r <= q_r + 1'b1;
        if ({1'b0, col_r} + 1'b1 >= cfg.width) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      odata_r <= val_r;
      olast_r <= fe;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("divider remainder out of range");
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    stat.frame_done |=> (q_r == '0 && col_r == '0 && row_r == '0))
    else $error("position not cleared at frame end");

endmodule

/* hw/rtl/weighted_three_tap_cost_aggregation.sv */
// Top level of the weighted three-tap cost aggregation block.
//   channel  direction  handshake          payload
//   in_      slave      tvalid/tready      tdata = cost, weight; tuser = req_type
//   out_     master     tvalid/tready      tdata = cost_result; tlast = frame_end
//   cfg_     write      we                 index 0..3, wdata 11 bits
// In the back part a pixel beat that gives no result is only written to the delay lines;
// one passed through at distance 0 or a copied border pixel also loads the output; an
// aggregated pixel reads both taps on the single read ports and runs the 8-step divider.
// Flushes ending a frame are taken only once the queue and back part are empty.
// Reset is synchronous; the delay lines are not cleared.
// A held output beat stalls the back part; the front keeps filling the queue until full.
module weighted_three_tap_cost_aggregation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] cost_pixel, [15:8] weight_pixel
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] cost_result
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic                       dir_r;
  logic [4:0]                 dist_r;
  logic [10:0]                fw_r, fh_r;
  logic [wtca_pkg::LAG_W-1:0] lag_r;
  logic [wtca_pkg::CNT_W-1:0] fs_r;
  logic [4:0]                 d_eff;
  logic [10:0]                w_eff, h_eff;
  logic [15:0]                dw;
  logic [21:0]                wh;

  wtca_pkg::cfg_t       cfg;
  wtca_pkg::back_stat_t stat;
  wtca_pkg::item_t      push_data, pop_data;
  logic                 q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= 1'b0;
      dist_r <= 5'd1;
      fw_r   <= 11'd640;
      fh_r   <= 11'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        wtca_pkg::CFG_DIR:    dir_r  <= cfg_wdata[0];
        wtca_pkg::CFG_DIST:   dist_r <= cfg_wdata[4:0];
        wtca_pkg::CFG_WIDTH:  fw_r   <= cfg_wdata;
        wtca_pkg::CFG_HEIGHT: fh_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    d_eff = (dist_r > 5'(wtca_pkg::MAX_DISTANCE)) ? 5'(wtca_pkg::MAX_DISTANCE) : dist_r;
    if (fw_r == '0)                              w_eff = 11'd1;
    else if (fw_r > 11'(wtca_pkg::MAX_WIDTH))    w_eff = 11'(wtca_pkg::MAX_WIDTH);
    else                                         w_eff = fw_r;
    if (fh_r == '0)                              h_eff = 11'd1;
    else if (fh_r > 11'(wtca_pkg::MAX_HEIGHT))   h_eff = 11'(wtca_pkg::MAX_HEIGHT);
    else                                         h_eff = fh_r;
  end

  assign dw = d_eff * w_eff;
  assign wh = w_eff * h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= 15'd640;
      fs_r  <= 21'd307200;
    end else begin
      lag_r <= dir_r ? wtca_pkg::LAG_W'(d_eff) : dw[wtca_pkg::LAG_W-1:0];
      fs_r  <= wh[wtca_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    cfg.dir      = dir_r;
    cfg.tap_dist = d_eff;
    cfg.width    = w_eff;
    cfg.height   = h_eff;
    cfg.lag      = lag_r;
    cfg.fsize    = fs_r;
  end

  wtca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_data    (push_data),
    .stat      (stat)
  );

  wtca_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  wtca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
